// ===== rtl/itt_pkg.sv =====
package itt_pkg;

  localparam int unsigned RpmW   = 16;
  localparam int unsigned TrimW  = 11;
  localparam int unsigned WeightW = 3;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned QueueDepth = 2;

  localparam logic [CfgIdxW-1:0] RegTrimMode  = 8'd0;
  localparam logic [CfgIdxW-1:0] RegIntensity = 8'd1;
  localparam logic [CfgIdxW-1:0] RegRpmLow    = 8'd2;
  localparam logic [CfgIdxW-1:0] RegRpmHigh   = 8'd3;

  typedef enum logic [2:0] {
    ModeStandard   = 3'd0,
    ModeSoft       = 3'd1,
    ModeResponsive = 3'd2,
    ModePatternA   = 3'd3,
    ModePatternB   = 3'd4,
    ModePatternC   = 3'd5,
    ModeCustom     = 3'd6,
    ModeInvalid    = 3'd7
  } trim_mode_e;

  localparam logic [3:0]      IntensityMax = 4'd10;
  localparam logic [RpmW-1:0] RpmLowMin    = 16'd500;
  localparam logic [RpmW-1:0] RpmHighMax   = 16'd5000;
  localparam logic [RpmW-1:0] ThrottleMax  = 16'd50;
  localparam logic [RpmW:0]   GuardBand    = 17'd100;
  localparam logic [4:0]      StepUnit     = 5'd20;
  localparam logic signed [12:0] TrimLimit = 13'sd800;

  localparam logic [TrimW-1:0] ResetMode      = 11'd0;
  localparam logic [3:0]       ResetIntensity = 4'd0;
  localparam logic [RpmW-1:0]  ResetRpmLow    = 16'd1150;
  localparam logic [RpmW-1:0]  ResetRpmHigh   = 16'd1700;

  typedef logic signed [WeightW-1:0] weight_t;

  typedef struct packed {
    trim_mode_e      mode;
    logic [3:0]      intensity;
    logic [RpmW-1:0] rpm_low;
    logic [RpmW-1:0] rpm_high;
  } cfg_t;

  // One queue entry: the signed pattern weight, already zeroed when the
  // event is inactive or a guard band suppresses it.
  typedef struct packed {
    weight_t weight;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  function automatic weight_t pat_a(input logic [2:0] idx);
    weight_t w;
    case (idx)
      3'd0: w = 3'sd2;
      3'd1: w = -3'sd1;
      3'd2: w = -3'sd2;
      3'd3: w = 3'sd1;
      3'd4: w = 3'sd2;
      3'd5: w = -3'sd1;
      3'd6: w = -3'sd3;
      default: w = 3'sd1;
    endcase
    return w;
  endfunction

  function automatic weight_t pat_b(input logic [3:0] idx);
    weight_t w;
    case (idx)
      4'd0, 4'd2, 4'd6, 4'd8: w = 3'sd2;
      4'd4, 4'd10:            w = 3'sd1;
      4'd5, 4'd11:            w = -3'sd3;
      default:                w = -3'sd2;
    endcase
    return w;
  endfunction

  function automatic weight_t pat_c(input logic [3:0] idx);
    weight_t w;
    case (idx)
      4'd0, 4'd4: w = 3'sd3;
      4'd1, 4'd5, 4'd7: w = -3'sd3;
      4'd2, 4'd8: w = 3'sd2;
      4'd6:       w = 3'sd1;
      default:    w = -3'sd2;
    endcase
    return w;
  endfunction

  function automatic weight_t pat_custom(input logic [2:0] idx);
    weight_t w;
    case (idx)
      3'd0: w = 3'sd2;
      3'd1: w = -3'sd2;
      3'd2: w = 3'sd1;
      3'd3: w = -3'sd1;
      3'd4: w = 3'sd3;
      3'd5: w = -3'sd3;
      3'd6: w = 3'sd1;
      default: w = -3'sd2;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/itt_in_if.sv =====
interface itt_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] engine_rpm;
  logic [15:0] throttle_pos;

  modport source (output valid, output engine_rpm, output throttle_pos, input ready);
  modport sink   (input valid, input engine_rpm, input throttle_pos, output ready);
endinterface

// ===== rtl/itt_out_if.sv =====
interface itt_out_if;
  logic               valid;
  logic               ready;
  logic signed [10:0] trim_centideg;

  modport source (output valid, output trim_centideg, input ready);
  modport sink   (input valid, input trim_centideg, output ready);
endinterface

// ===== rtl/itt_cfg_if.sv =====
interface itt_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/ignition_timing_trim_pattern_top.sv =====
// Spark timing trim generator: one request per combustion event (engine speed and
// throttle) gives one signed trim in hundredths of a degree, in request order. The
// block takes a new request every clock cycle while its input ready is high; the
// result is written into the queue at the accepting edge and then into the output
// register, from which it is presented. Stalls on the output side are absorbed by
// the two-entry queue before the input ready drops. Configuration registers (index
// 0 mode, 1 intensity, 2 low speed limit, 3 high speed limit) are written through
// the configuration channel, which is always ready, and must only be written while
// no request is in flight.
module ignition_timing_trim_pattern_top (
  input  logic clk_i,
  input  logic rst_ni,
  itt_cfg_if.sink   cfg_i,
  itt_in_if.sink    in_i,
  itt_out_if.source out_o
);
  import itt_pkg::*;

  cfg_t   cfg_q;
  push_t  push;
  push_t  head;
  logic   push_ready;
  logic   pop;
  logic   cfg_write;

  assign cfg_i.ready = 1'b1;
  assign cfg_write   = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode      <= ModeStandard;
      cfg_q.intensity <= ResetIntensity;
      cfg_q.rpm_low   <= ResetRpmLow;
      cfg_q.rpm_high  <= ResetRpmHigh;
    end else if (cfg_write) begin
      case (cfg_i.index)
        RegTrimMode:  cfg_q.mode      <= trim_mode_e'(cfg_i.data[2:0]);
        RegIntensity: cfg_q.intensity <= cfg_i.data[3:0];
        RegRpmLow:    cfg_q.rpm_low   <= cfg_i.data;
        RegRpmHigh:   cfg_q.rpm_high  <= cfg_i.data;
        default:      ;
      endcase
    end
  end

  itt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_i         (in_i),
    .push_ready_i (push_ready),
    .push_o       (push)
  );

  itt_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .head_o       (head),
    .pop_i        (pop)
  );

  itt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .intensity_i (cfg_q.intensity),
    .head_i      (head),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

// ===== rtl/itt_front.sv =====
module itt_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  itt_pkg::cfg_t      cfg_i,
  itt_in_if.sink             in_i,
  input  logic               push_ready_i,
  output itt_pkg::push_t     push_o
);
  import itt_pkg::*;

  logic [7:0] phase_q, phase_d;
  logic [3:0] mod12_q, mod12_d;
  logic [3:0] mod10_q, mod10_d;

  logic       cfg_ok;
  logic       active;
  logic       accept;
  logic       low_guard;
  logic       high_guard;
  logic [7:0] phase_n;
  logic [3:0] mod12_n;
  logic [3:0] mod10_n;
  weight_t    weight_raw;
  weight_t    weight;

  assign cfg_ok = (cfg_i.mode != ModeInvalid) && (cfg_i.intensity <= IntensityMax) &&
                  (cfg_i.rpm_low >= RpmLowMin) && (cfg_i.rpm_high <= RpmHighMax) &&
                  (cfg_i.rpm_low < cfg_i.rpm_high);

  assign active = cfg_ok && (cfg_i.mode != ModeStandard) && (cfg_i.intensity != 4'd0) &&
                  (in_i.engine_rpm >= cfg_i.rpm_low) &&
                  (in_i.engine_rpm <= cfg_i.rpm_high) &&
                  (in_i.throttle_pos <= ThrottleMax);

  assign in_i.ready = push_ready_i;
  assign accept     = in_i.valid && push_ready_i;

  // The residues modulo 12 and 10 follow the phase counter, restarting
  // together with it when it wraps from 255 to 0.
  assign phase_n = phase_q + 8'd1;
  assign mod12_n = (phase_q == 8'hFF || mod12_q == 4'd11) ? 4'd0 : mod12_q + 4'd1;
  assign mod10_n = (phase_q == 8'hFF || mod10_q == 4'd9)  ? 4'd0 : mod10_q + 4'd1;

  always_comb begin
    case (cfg_i.mode)
      ModeSoft:       weight_raw = -3'sd1;
      ModeResponsive: weight_raw = 3'sd1;
      ModePatternA:   weight_raw = pat_a(phase_n[2:0]);
      ModePatternB:   weight_raw = pat_b(mod12_n);
      ModePatternC:   weight_raw = pat_c(mod10_n);
      default:        weight_raw = pat_custom(phase_n[2:0]);
    endcase
  end

  assign low_guard  = {1'b0, in_i.engine_rpm} <= ({1'b0, cfg_i.rpm_low} + GuardBand);
  assign high_guard = ({1'b0, in_i.engine_rpm} + GuardBand) >= {1'b0, cfg_i.rpm_high};

  always_comb begin
    weight = weight_raw;
    if (!active) begin
      weight = '0;
    end else if (weight_raw < 0 && low_guard) begin
      weight = '0;
    end else if (weight_raw > 0 && high_guard) begin
      weight = '0;
    end
  end

  assign push_o.valid        = in_i.valid;
  assign push_o.entry.weight = weight;

  always_comb begin
    phase_d = phase_q;
    mod12_d = mod12_q;
    mod10_d = mod10_q;
    if (accept && active) begin
      phase_d = phase_n;
      mod12_d = mod12_n;
      mod10_d = mod10_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      mod12_q <= '0;
      mod10_q <= '0;
    end else begin
      phase_q <= phase_d;
      mod12_q <= mod12_d;
      mod10_q <= mod10_d;
    end
  end

  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !active) |=> $stable(phase_q))
    else $error("phase moved on an inactive event");

  a_residue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mod12_q < 4'd12) && (mod10_q < 4'd10))
    else $error("phase residue out of range");

  a_residue_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == 8'd0) |-> (mod12_q == 4'd0 && mod10_q == 4'd0))
    else $error("phase residues not aligned at phase zero");

endmodule

// ===== rtl/itt_fifo.sv =====
module itt_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  itt_pkg::push_t    push_i,
  output logic              push_ready_o,
  output itt_pkg::push_t    head_o,
  input  logic              pop_i
);
  import itt_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  entry_t          mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push;
  logic            pop;

  assign push_ready_o = count_q != CntW'(QueueDepth);
  assign push         = push_i.valid && push_ready_o;
  assign pop          = pop_i && (count_q != '0);

  assign head_o.valid = count_q != '0;
  assign head_o.entry = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({push, pop})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("queue count overflow");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("queue count did not follow a push");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers apart while empty");

endmodule

// ===== rtl/itt_back.sv =====
module itt_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [3:0]        intensity_i,
  input  itt_pkg::push_t    head_i,
  output logic              pop_o,
  itt_out_if.source         out_o
);
  import itt_pkg::*;

  logic                    out_valid_q, out_valid_d;
  logic signed [TrimW-1:0] trim_q;
  logic signed [TrimW-1:0] trim_d;
  logic [8:0]              step;
  logic signed [12:0]      product;

  assign step    = 9'(intensity_i * StepUnit);
  assign product = 13'(13'(signed'(head_i.entry.weight)) * signed'({4'd0, step}));

  always_comb begin
    if (product > TrimLimit) begin
      trim_d = TrimW'(TrimLimit);
    end else if (product < -TrimLimit) begin
      trim_d = TrimW'(-TrimLimit);
    end else begin
      trim_d = TrimW'(product);
    end
  end

  assign pop_o       = head_i.valid && (!out_valid_q || out_o.ready);
  assign out_valid_d = pop_o || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      trim_q <= trim_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.trim_centideg = trim_q;

  a_trim_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (trim_q <= 11'sd800 && trim_q >= -11'sd800))
    else $error("trim outside the clamp range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !pop_o)
    else $error("held result overwritten");

  a_pop_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q)
    else $error("popped entry did not reach the output");

endmodule
